### sv/spnm_pkg.sv
// Shared types, widths and datapath operation codes for the sorted palette matcher.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package spnm_pkg;

    localparam int ADDR_W = 16;
    localparam int CNT_W  = 17;
    localparam int PTR_W  = 18;
    localparam int KEY_W  = 24;
    localparam int COL_W  = 32;
    localparam int IN_W   = 64;
    localparam int OUT_W  = 80;
    localparam logic [CNT_W-1:0] DEPTH = 17'd65536;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] MODE_BISECT = 2'd0;
    localparam logic [1:0] MODE_LOWER  = 2'd1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
    localparam logic [OP_W-1:0] OP_CAPTURE   = 5'd1;
    localparam logic [OP_W-1:0] OP_RES_FULL  = 5'd2;
    localparam logic [OP_W-1:0] OP_RES_EMPTY = 5'd3;
    localparam logic [OP_W-1:0] OP_CLEAR     = 5'd4;
    localparam logic [OP_W-1:0] OP_INIT_BI   = 5'd5;
    localparam logic [OP_W-1:0] OP_INIT_LB   = 5'd6;
    localparam logic [OP_W-1:0] OP_RD_MID    = 5'd7;
    localparam logic [OP_W-1:0] OP_STEP_BI   = 5'd8;
    localparam logic [OP_W-1:0] OP_STEP_LB   = 5'd9;
    localparam logic [OP_W-1:0] OP_STEP_UB   = 5'd10;
    localparam logic [OP_W-1:0] OP_RD_LO     = 5'd11;
    localparam logic [OP_W-1:0] OP_RD_LOM1   = 5'd12;
    localparam logic [OP_W-1:0] OP_BI_CLOSE  = 5'd13;
    localparam logic [OP_W-1:0] OP_IDX_LO    = 5'd14;
    localparam logic [OP_W-1:0] OP_IDX_LAST  = 5'd15;
    localparam logic [OP_W-1:0] OP_IDX_ZERO  = 5'd16;
    localparam logic [OP_W-1:0] OP_IDX_LB    = 5'd17;
    localparam logic [OP_W-1:0] OP_IDX_MID   = 5'd18;
    localparam logic [OP_W-1:0] OP_RD_IDX    = 5'd19;
    localparam logic [OP_W-1:0] OP_TAKE      = 5'd20;
    localparam logic [OP_W-1:0] OP_RM_RD     = 5'd21;
    localparam logic [OP_W-1:0] OP_RM_WR     = 5'd22;
    localparam logic [OP_W-1:0] OP_RM_DONE   = 5'd23;
    localparam logic [OP_W-1:0] OP_INS_START = 5'd24;
    localparam logic [OP_W-1:0] OP_INS_RD    = 5'd25;
    localparam logic [OP_W-1:0] OP_INS_WR    = 5'd26;
    localparam logic [OP_W-1:0] OP_INS_PUT   = 5'd27;
    localparam logic [OP_W-1:0] OP_PUBLISH   = 5'd28;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic lo_eq_hi;
        logic hi_neg;
        logic lo_gt_hi;
        logic lo_lt_hi;
        logic lo_ge_count;
        logic key_eq;
        logic rm_more;
        logic ins_more;
    } dp_status_t;

endpackage
`default_nettype wire

### sv/sorted_palette_nearest_matcher.sv
// Top level of the sorted palette matcher: ports, controller and datapath, and assertions.
// Depends on spnm_pkg, spnm_controller and spnm_datapath.
`timescale 1ns / 1ps
`default_nettype none
// The block holds up to 65536 palette entries (24-bit key, 32-bit color) sorted by key in
// one on-chip memory. A load word inserts an entry after any equal keys, a query word picks
// one entry under match_mode (bisection nearest, lower bound, or smallest entry), returns it
// and removes it, and a clear word empties the table. Every input word yields exactly one
// output word. One word is worked at a time. Each search probe is a memory read and a compare,
// with at most log2(count)+1 probes, and the insert or remove shift then moves each entry
// behind the chosen slot by a read and a write of the memory. A finished result is published
// only once the previous result has been taken on m_tready. The output register decouples the
// sides: a finished word waits there while the next input word is taken. The mode register
// may be written at any time the block is idle.
module sorted_palette_nearest_matcher
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // command [1:0], key [25:2], entry_color [57:26], zero fill [63:58]
    input  wire logic [63:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // match_color [31:0], match_key [55:32], status [57:56], entries_left [74:58], zero [79:75]
    output logic [79:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data
);

    spnm_pkg::dp_cmd_t    cmd;
    spnm_pkg::dp_status_t sts;

    spnm_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_command (s_tdata[1:0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .sts       (sts),
        .cmd       (cmd)
    );

    spnm_datapath u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .sts     (sts),
        .m_tdata (m_tdata)
    );

    // After a word is taken the block is busy until its result is queued.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // The count never exceeds the table depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[74:58] <= spnm_pkg::DEPTH))
        else $error("entries_left out of range");

    // A full status only comes with a full table, an empty status with an empty one.
    a_status_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[57:56] != spnm_pkg::ST_FULL)
                      || (m_tdata[74:58] == spnm_pkg::DEPTH))
                  && ((m_tdata[57:56] != spnm_pkg::ST_EMPTY) || (m_tdata[74:58] == 17'd0)))
        else $error("status disagrees with entries_left");

    // A result is raised only as the block returns to idle.
    a_publish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result raised outside publish");

endmodule
`default_nettype wire

### sv/spnm_datapath.sv
// Datapath of the sorted palette matcher: entry memory, search bounds and result word.
// Depends on spnm_pkg; driven by spnm_controller through operation codes.
`timescale 1ns / 1ps
`default_nettype none
module spnm_datapath
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [spnm_pkg::IN_W-1:0]   s_tdata,
    input  wire spnm_pkg::dp_cmd_t           cmd,
    output spnm_pkg::dp_status_t             sts,
    output logic [spnm_pkg::OUT_W-1:0]       m_tdata
);

    localparam int ENT_W = spnm_pkg::KEY_W + spnm_pkg::COL_W;

    logic [ENT_W-1:0] mem [0:(1 << spnm_pkg::ADDR_W)-1];
    logic [ENT_W-1:0] rd_data_reg;

    logic [spnm_pkg::CNT_W-1:0] count_reg, count_next;
    logic signed [spnm_pkg::PTR_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic signed [spnm_pkg::PTR_W-1:0] mid_reg, mid_next, ptr_reg, ptr_next;
    logic signed [spnm_pkg::PTR_W-1:0] idx_reg, idx_next;
    logic [spnm_pkg::KEY_W-1:0] key_reg, key_next, vh_reg, vh_next;
    logic [spnm_pkg::COL_W-1:0] color_reg, color_next;
    logic [spnm_pkg::COL_W-1:0] res_color_reg, res_color_next;
    logic [spnm_pkg::KEY_W-1:0] res_key_reg, res_key_next;
    logic [1:0] res_status_reg, res_status_next;
    logic [spnm_pkg::OUT_W-1:0] out_reg, out_next;

    logic signed [spnm_pkg::PTR_W-1:0] count_s, mid_calc;
    logic [spnm_pkg::PTR_W:0] mid_sum;
    logic [spnm_pkg::KEY_W-1:0] rd_key, dh, dl;
    logic [spnm_pkg::COL_W-1:0] rd_color;
    logic rd_en, wr_en;
    logic [spnm_pkg::ADDR_W-1:0] rd_addr, wr_addr;
    logic [ENT_W-1:0] wr_data;

    assign count_s  = $signed({1'b0, count_reg});
    assign mid_sum  = {lo_reg[spnm_pkg::PTR_W-1], lo_reg} + {hi_reg[spnm_pkg::PTR_W-1], hi_reg};
    assign mid_calc = $signed(mid_sum[spnm_pkg::PTR_W:1]);
    assign rd_key   = rd_data_reg[ENT_W-1:spnm_pkg::COL_W];
    assign rd_color = rd_data_reg[spnm_pkg::COL_W-1:0];
    assign dh       = (vh_reg > key_reg) ? (vh_reg - key_reg) : (key_reg - vh_reg);
    assign dl       = key_reg - rd_key;

    assign sts.full        = (count_reg >= spnm_pkg::DEPTH);
    assign sts.empty       = (count_reg == '0);
    assign sts.lo_eq_hi    = (lo_reg == hi_reg);
    assign sts.hi_neg      = hi_reg[spnm_pkg::PTR_W-1];
    assign sts.lo_gt_hi    = (lo_reg > hi_reg);
    assign sts.lo_lt_hi    = (lo_reg < hi_reg);
    assign sts.lo_ge_count = (lo_reg >= count_s);
    assign sts.key_eq      = (rd_key == key_reg);
    assign sts.rm_more     = ((ptr_reg + 18'sd1) < count_s);
    assign sts.ins_more    = (ptr_reg >= lo_reg);

    always_comb
    begin
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        ptr_next        = ptr_reg;
        idx_next        = idx_reg;
        key_next        = key_reg;
        vh_next         = vh_reg;
        color_next      = color_reg;
        res_color_next  = res_color_reg;
        res_key_next    = res_key_reg;
        res_status_next = res_status_reg;
        out_next        = out_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = rd_data_reg;
        case (cmd.op)
            spnm_pkg::OP_CAPTURE:
            begin
                key_next        = s_tdata[25:2];
                color_next      = s_tdata[57:26];
                res_color_next  = '0;
                res_key_next    = '0;
                res_status_next = spnm_pkg::ST_OK;
            end
            spnm_pkg::OP_RES_FULL:  res_status_next = spnm_pkg::ST_FULL;
            spnm_pkg::OP_RES_EMPTY: res_status_next = spnm_pkg::ST_EMPTY;
            spnm_pkg::OP_CLEAR:     count_next = '0;
            spnm_pkg::OP_INIT_BI:
            begin
                lo_next = '0;
                hi_next = count_s - 18'sd1;
            end
            spnm_pkg::OP_INIT_LB:
            begin
                lo_next = '0;
                hi_next = count_s;
            end
            spnm_pkg::OP_RD_MID:
            begin
                mid_next = mid_calc;
                rd_en    = 1'b1;
                rd_addr  = mid_calc[spnm_pkg::ADDR_W-1:0];
            end
            spnm_pkg::OP_STEP_BI:
            begin
                if (rd_key > key_reg)
                begin
                    hi_next = mid_reg - 18'sd1;
                end
                else
                begin
                    lo_next = mid_reg + 18'sd1;
                end
            end
            spnm_pkg::OP_STEP_LB:
            begin
                if (rd_key < key_reg)
                begin
                    lo_next = mid_reg + 18'sd1;
                end
                else
                begin
                    hi_next = mid_reg;
                end
            end
            spnm_pkg::OP_STEP_UB:
            begin
                if (rd_key <= key_reg)
                begin
                    lo_next = mid_reg + 18'sd1;
                end
                else
                begin
                    hi_next = mid_reg;
                end
            end
            spnm_pkg::OP_RD_LO:
            begin
                rd_en   = 1'b1;
                rd_addr = lo_reg[spnm_pkg::ADDR_W-1:0];
            end
            spnm_pkg::OP_RD_LOM1:
            begin
                vh_next = rd_key;
                rd_en   = 1'b1;
                rd_addr = lo_next[spnm_pkg::ADDR_W-1:0] - 16'd1;
            end
            spnm_pkg::OP_BI_CLOSE:
            begin
                // Data register now holds the lower neighbor's key.
                if (rd_key > key_reg)
                begin
                    idx_next = lo_reg - 18'sd1;
                end
                else if (dh < dl)
                begin
                    idx_next = lo_reg;
                end
                else
                begin
                    idx_next = lo_reg - 18'sd1;
                end
            end
            spnm_pkg::OP_IDX_LO:   idx_next = lo_reg;
            spnm_pkg::OP_IDX_LAST: idx_next = count_s - 18'sd1;
            spnm_pkg::OP_IDX_ZERO: idx_next = '0;
            spnm_pkg::OP_IDX_LB:   idx_next = sts.lo_ge_count ? (count_s - 18'sd1) : lo_reg;
            spnm_pkg::OP_IDX_MID:  idx_next = mid_reg;
            spnm_pkg::OP_RD_IDX:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg[spnm_pkg::ADDR_W-1:0];
            end
            spnm_pkg::OP_TAKE:
            begin
                res_color_next = rd_color;
                res_key_next   = rd_key;
                ptr_next       = idx_reg;
            end
            spnm_pkg::OP_RM_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = ptr_reg[spnm_pkg::ADDR_W-1:0] + 16'd1;
            end
            spnm_pkg::OP_RM_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[spnm_pkg::ADDR_W-1:0];
                ptr_next = ptr_reg + 18'sd1;
            end
            spnm_pkg::OP_RM_DONE: count_next = count_reg - 17'd1;
            spnm_pkg::OP_INS_START: ptr_next = count_s - 18'sd1;
            spnm_pkg::OP_INS_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = ptr_reg[spnm_pkg::ADDR_W-1:0];
            end
            spnm_pkg::OP_INS_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[spnm_pkg::ADDR_W-1:0] + 16'd1;
                ptr_next = ptr_reg - 18'sd1;
            end
            spnm_pkg::OP_INS_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = lo_reg[spnm_pkg::ADDR_W-1:0];
                wr_data    = {key_reg, color_reg};
                count_next = count_reg + 17'd1;
            end
            spnm_pkg::OP_PUBLISH:
                out_next = {5'd0, count_reg, res_status_reg, res_key_reg, res_color_reg};
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        ptr_reg        <= ptr_next;
        idx_reg        <= idx_next;
        key_reg        <= key_next;
        vh_reg         <= vh_next;
        color_reg      <= color_next;
        res_color_reg  <= res_color_next;
        res_key_reg    <= res_key_next;
        res_status_reg <= res_status_next;
        out_reg        <= out_next;
    end

    assign m_tdata = out_reg;

endmodule
`default_nettype wire

### sv/spnm_controller.sv
// Controller state machine of the sorted palette matcher: handshakes, mode register, sequencing.
// Depends on spnm_pkg; steers spnm_datapath through operation codes.
`timescale 1ns / 1ps
`default_nettype none
module spnm_controller
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [1:0]        s_command,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_data,
    input  wire spnm_pkg::dp_status_t sts,
    output spnm_pkg::dp_cmd_t      cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_BS_CHK   = 4'd2;
    localparam logic [3:0] S_BS_CMP   = 4'd3;
    localparam logic [3:0] S_BI_CHK   = 4'd4;
    localparam logic [3:0] S_BI_CMP   = 4'd5;
    localparam logic [3:0] S_BI_RDL   = 4'd6;
    localparam logic [3:0] S_BI_END   = 4'd7;
    localparam logic [3:0] S_PICK_RD  = 4'd8;
    localparam logic [3:0] S_PICK_TK  = 4'd9;
    localparam logic [3:0] S_RM_CHK   = 4'd10;
    localparam logic [3:0] S_RM_WR    = 4'd11;
    localparam logic [3:0] S_INS_CHK  = 4'd12;
    localparam logic [3:0] S_INS_WR   = 4'd13;
    localparam logic [3:0] S_DONE     = 4'd14;

    logic [3:0] state_reg, state_next;
    logic [1:0] cmd_reg, cmd_next;
    logic [1:0] mode_reg;
    logic       valid_reg, valid_next;
    logic [spnm_pkg::OP_W-1:0] op;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = valid_reg;
    assign cmd.op    = op;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        valid_next = valid_reg && !m_tready;
        op         = spnm_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op         = spnm_pkg::OP_CAPTURE;
                    cmd_next   = s_command;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_DONE;
                case (cmd_reg)
                    spnm_pkg::CMD_LOAD:
                    begin
                        if (sts.full)
                        begin
                            op = spnm_pkg::OP_RES_FULL;
                        end
                        else
                        begin
                            op         = spnm_pkg::OP_INIT_LB;
                            state_next = S_BS_CHK;
                        end
                    end
                    spnm_pkg::CMD_QUERY:
                    begin
                        if (sts.empty)
                        begin
                            op = spnm_pkg::OP_RES_EMPTY;
                        end
                        else if (mode_reg == spnm_pkg::MODE_BISECT)
                        begin
                            op         = spnm_pkg::OP_INIT_BI;
                            state_next = S_BI_CHK;
                        end
                        else if (mode_reg == spnm_pkg::MODE_LOWER)
                        begin
                            op         = spnm_pkg::OP_INIT_LB;
                            state_next = S_BS_CHK;
                        end
                        else
                        begin
                            op         = spnm_pkg::OP_IDX_ZERO;
                            state_next = S_PICK_RD;
                        end
                    end
                    spnm_pkg::CMD_CLEAR: op = spnm_pkg::OP_CLEAR;
                    default:             op = spnm_pkg::OP_NONE;
                endcase
            end
            S_BS_CHK:
            begin
                if (sts.lo_lt_hi)
                begin
                    op         = spnm_pkg::OP_RD_MID;
                    state_next = S_BS_CMP;
                end
                else if (cmd_reg == spnm_pkg::CMD_LOAD)
                begin
                    op         = spnm_pkg::OP_INS_START;
                    state_next = S_INS_CHK;
                end
                else
                begin
                    op         = spnm_pkg::OP_IDX_LB;
                    state_next = S_PICK_RD;
                end
            end
            S_BS_CMP:
            begin
                op = (cmd_reg == spnm_pkg::CMD_LOAD) ? spnm_pkg::OP_STEP_UB
                                                      : spnm_pkg::OP_STEP_LB;
                state_next = S_BS_CHK;
            end
            S_BI_CHK:
            begin
                if (sts.lo_eq_hi || sts.hi_neg)
                begin
                    op         = spnm_pkg::OP_IDX_LO;
                    state_next = S_PICK_RD;
                end
                else if (sts.lo_gt_hi)
                begin
                    if (sts.lo_ge_count)
                    begin
                        op         = spnm_pkg::OP_IDX_LAST;
                        state_next = S_PICK_RD;
                    end
                    else
                    begin
                        op         = spnm_pkg::OP_RD_LO;
                        state_next = S_BI_RDL;
                    end
                end
                else
                begin
                    op         = spnm_pkg::OP_RD_MID;
                    state_next = S_BI_CMP;
                end
            end
            S_BI_CMP:
            begin
                if (sts.key_eq)
                begin
                    op         = spnm_pkg::OP_IDX_MID;
                    state_next = S_PICK_RD;
                end
                else
                begin
                    op         = spnm_pkg::OP_STEP_BI;
                    state_next = S_BI_CHK;
                end
            end
            S_BI_RDL:
            begin
                op         = spnm_pkg::OP_RD_LOM1;
                state_next = S_BI_END;
            end
            S_BI_END:
            begin
                op         = spnm_pkg::OP_BI_CLOSE;
                state_next = S_PICK_RD;
            end
            S_PICK_RD:
            begin
                op         = spnm_pkg::OP_RD_IDX;
                state_next = S_PICK_TK;
            end
            S_PICK_TK:
            begin
                op         = spnm_pkg::OP_TAKE;
                state_next = S_RM_CHK;
            end
            S_RM_CHK:
            begin
                if (sts.rm_more)
                begin
                    op         = spnm_pkg::OP_RM_RD;
                    state_next = S_RM_WR;
                end
                else
                begin
                    op         = spnm_pkg::OP_RM_DONE;
                    state_next = S_DONE;
                end
            end
            S_RM_WR:
            begin
                op         = spnm_pkg::OP_RM_WR;
                state_next = S_RM_CHK;
            end
            S_INS_CHK:
            begin
                if (sts.ins_more)
                begin
                    op         = spnm_pkg::OP_INS_RD;
                    state_next = S_INS_WR;
                end
                else
                begin
                    op         = spnm_pkg::OP_INS_PUT;
                    state_next = S_DONE;
                end
            end
            S_INS_WR:
            begin
                op         = spnm_pkg::OP_INS_WR;
                state_next = S_INS_CHK;
            end
            S_DONE:
            begin
                if (!valid_reg || m_tready)
                begin
                    op         = spnm_pkg::OP_PUBLISH;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg   <= spnm_pkg::CMD_LOAD;
            mode_reg  <= spnm_pkg::MODE_BISECT;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            valid_reg <= valid_next;
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

endmodule
`default_nettype wire
